/* sv/smpp_pkg.sv */
// Shared types and constants of the score margin peak picker.
package smpp_pkg;

    // Margin and configuration widths are fixed by the register map.
    localparam int MARGIN_W   = 16;
    localparam int RADIUS_W   = 4;
    localparam int THRESH_W   = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 1;

    localparam logic [MARGIN_W-1:0] MARGIN_MAX   = 16'hFFFF;
    localparam logic [RADIUS_W-1:0] RADIUS_RESET = 4'd2;
    localparam logic [THRESH_W-1:0] THRESH_RESET = 16'd0;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS           = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MARGIN_THRESHOLD = 1'b1;

    // Depth of the column queue between front and back.
    localparam int QUEUE_DEPTH = 4;

    // One finished column as handed from front to back.
    typedef struct packed {
        logic [MARGIN_W-1:0] margin;
        logic                seq_end;
    } col_event_t;

    typedef enum logic {
        BACK_IDLE,
        BACK_EMIT
    } back_state_t;

endpackage

/* sv/smpp_front.sv */
// Front end: accepts scores, tracks best and second best, forms column margins.
module smpp_front #(
    parameter int SCORE_BITS = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [SCORE_BITS-1:0]  score,
    input  logic                   column_end,
    input  logic                   sequence_end,
    output logic                   ev_valid,
    input  logic                   ev_ready,
    output smpp_pkg::col_event_t   ev
);

    localparam int DW = (SCORE_BITS + 1 > smpp_pkg::MARGIN_W + 1) ?
                        SCORE_BITS + 1 : smpp_pkg::MARGIN_W + 1;
    localparam logic [SCORE_BITS-1:0] SCORE_FLOOR = {1'b1, {(SCORE_BITS-1){1'b0}}};

    logic [SCORE_BITS-1:0] best_reg, best_next;
    logic [SCORE_BITS-1:0] second_reg, second_next;
    logic [1:0]            rows_seen_reg;
    logic                  accept;
    logic                  col_done;
    logic [DW-1:0]         best_x;
    logic [DW-1:0]         second_x;
    logic [DW-1:0]         diff;
    logic [smpp_pkg::MARGIN_W-1:0] margin;

    assign in_ready = ev_ready;
    assign accept   = in_valid && in_ready;
    assign col_done = column_end || sequence_end;

    // Running best and second best including the current score.
    always_comb
    begin
        best_next   = best_reg;
        second_next = second_reg;
        if (rows_seen_reg == 2'd0)
        begin
            best_next   = score;
            second_next = SCORE_FLOOR;
        end
        else if ($signed(score) > $signed(best_reg))
        begin
            second_next = best_reg;
            best_next   = score;
        end
        else if ($signed(score) > $signed(second_reg))
        begin
            second_next = score;
        end
    end

    // Margin is the difference, clamped to the unsigned 16-bit range.
    always_comb
    begin
        best_x   = {{(DW-SCORE_BITS){best_next[SCORE_BITS-1]}}, best_next};
        second_x = {{(DW-SCORE_BITS){second_next[SCORE_BITS-1]}}, second_next};
        diff     = best_x - second_x;
        if (diff[DW-1])
            margin = '0;
        else if (diff > {{(DW-smpp_pkg::MARGIN_W){1'b0}}, smpp_pkg::MARGIN_MAX})
            margin = smpp_pkg::MARGIN_MAX;
        else
            margin = diff[smpp_pkg::MARGIN_W-1:0];
    end

    assign ev_valid   = accept && col_done;
    assign ev.margin  = margin;
    assign ev.seq_end = sequence_end;

    // Column statistics registers; a column end starts a fresh column.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_reg      <= SCORE_FLOOR;
            second_reg    <= SCORE_FLOOR;
            rows_seen_reg <= 2'd0;
        end
        else if (accept)
        begin
            if (col_done)
            begin
                best_reg      <= SCORE_FLOOR;
                second_reg    <= SCORE_FLOOR;
                rows_seen_reg <= 2'd0;
            end
            else
            begin
                best_reg   <= best_next;
                second_reg <= second_next;
                if (rows_seen_reg != 2'd2)
                    rows_seen_reg <= rows_seen_reg + 2'd1;
            end
        end
    end

endmodule

/* sv/smpp_fifo.sv */
// Short queue of finished columns between the front and back ends.
module smpp_fifo (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_valid,
    output logic                 wr_ready,
    input  smpp_pkg::col_event_t wr_data,
    output logic                 rd_valid,
    input  logic                 rd_ready,
    output smpp_pkg::col_event_t rd_data
);

    localparam int PTR_W = $clog2(smpp_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(smpp_pkg::QUEUE_DEPTH + 1);

    smpp_pkg::col_event_t    entry_reg [smpp_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]        wr_ptr_reg;
    logic [PTR_W-1:0]        rd_ptr_reg;
    logic [CNT_W-1:0]        fill_reg;
    logic                    do_wr;
    logic                    do_rd;

    assign wr_ready = (fill_reg != CNT_W'(smpp_pkg::QUEUE_DEPTH));
    assign rd_valid = (fill_reg != '0);
    assign rd_data  = entry_reg[rd_ptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_wr)
            entry_reg[wr_ptr_reg] <= wr_data;
    end

    // Pointers and fill level.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(smpp_pkg::QUEUE_DEPTH - 1)) ?
                              '0 : wr_ptr_reg + PTR_W'(1);
            if (do_rd)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(smpp_pkg::QUEUE_DEPTH - 1)) ?
                              '0 : rd_ptr_reg + PTR_W'(1);
            if (do_wr && !do_rd)
                fill_reg <= fill_reg + CNT_W'(1);
            else if (do_rd && !do_wr)
                fill_reg <= fill_reg - CNT_W'(1);
        end
    end

endmodule

/* sv/smpp_back.sv */
// Back end: margin window, suppression decisions and the output register.
module smpp_back #(
    parameter int MAX_RADIUS  = 15,
    parameter int MAX_COLUMNS = 1024
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [smpp_pkg::RADIUS_W-1:0]     radius,
    input  logic [smpp_pkg::THRESH_W-1:0]     margin_threshold,
    input  logic                              ev_valid,
    output logic                              ev_ready,
    input  smpp_pkg::col_event_t              ev,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [$clog2(MAX_COLUMNS)-1:0]    column_index,
    output logic                              is_peak,
    output logic                              last
);

    localparam int WIN   = 2 * MAX_RADIUS + 1;
    localparam int WI_W  = $clog2(WIN);
    localparam int K_W   = $clog2(MAX_RADIUS + 1);
    localparam int CNT_W = $clog2(2 * MAX_COLUMNS);
    localparam int IDX_W = $clog2(MAX_COLUMNS);
    localparam logic [CNT_W-1:0] COUNT_MAX = CNT_W'(2 * MAX_COLUMNS - 1);

    smpp_pkg::back_state_t          state_reg, state_next;
    logic [smpp_pkg::MARGIN_W-1:0]  win_reg [WIN];
    logic [smpp_pkg::MARGIN_W-1:0]  win_next [WIN];
    logic [CNT_W-1:0]               count_reg, count_next;
    logic [K_W-1:0]                 k_reg, k_next;
    logic                           flush_reg, flush_next;
    logic                           out_valid_reg, out_valid_next;
    logic [IDX_W-1:0]               index_reg, index_next;
    logic                           peak_reg, peak_next;
    logic                           last_reg, last_next;
    logic [K_W-1:0]                 r_eff;
    logic [CNT_W-1:0]               count_inc;
    logic [smpp_pkg::MARGIN_W-1:0]  center;
    logic [WIN-1:0]                 beaten;
    logic                           peak_now;
    logic [CNT_W-1:0]               col_now;
    logic                           slot_free;

    // Radius values beyond the window depth act as the deepest radius.
    assign r_eff = (int'(radius) > MAX_RADIUS) ? K_W'(MAX_RADIUS) : K_W'(radius);

    assign count_inc = (count_reg < COUNT_MAX) ? count_reg + CNT_W'(1) : count_reg;
    assign slot_free = !out_valid_reg || out_ready;

    // Peak at k: above threshold and no neighbor within the radius exceeds it.
    always_comb
    begin
        center = win_reg[WI_W'(k_reg)];
        for (int j = 0; j < WIN; j++)
        begin
            beaten[j] = (j + int'(r_eff) >= int'(k_reg)) &&
                        (j <= int'(k_reg) + int'(r_eff)) &&
                        (win_reg[j] > center);
        end
        peak_now = !(|beaten) && (center > margin_threshold);
        col_now  = count_reg - CNT_W'(k_reg) - CNT_W'(1);
    end

    // Sequencer: shift in a column, decide the center entry; sequence ends flush.
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        k_next         = k_reg;
        flush_next     = flush_reg;
        out_valid_next = out_valid_reg && !out_ready;
        index_next     = index_reg;
        peak_next      = peak_reg;
        last_next      = last_reg;
        ev_ready       = 1'b0;
        for (int j = 0; j < WIN; j++)
            win_next[j] = win_reg[j];

        case (state_reg)
            smpp_pkg::BACK_IDLE:
            begin
                ev_ready = 1'b1;
                if (ev_valid)
                begin
                    win_next[0] = ev.margin;
                    for (int j = 1; j < WIN; j++)
                        win_next[j] = win_reg[j-1];
                    count_next = count_inc;
                    flush_next = ev.seq_end;
                    if (ev.seq_end)
                    begin
                        k_next     = (count_inc > CNT_W'(r_eff)) ?
                                     r_eff : K_W'(count_inc - CNT_W'(1));
                        state_next = smpp_pkg::BACK_EMIT;
                    end
                    else if (count_inc > CNT_W'(r_eff))
                    begin
                        k_next     = r_eff;
                        state_next = smpp_pkg::BACK_EMIT;
                    end
                end
            end
            smpp_pkg::BACK_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    index_next     = col_now[IDX_W-1:0];
                    peak_next      = peak_now;
                    last_next      = flush_reg && (k_reg == '0);
                    if (!flush_reg || k_reg == '0)
                    begin
                        state_next = smpp_pkg::BACK_IDLE;
                        if (flush_reg)
                        begin
                            count_next = '0;
                            for (int j = 0; j < WIN; j++)
                                win_next[j] = '0;
                        end
                    end
                    else
                    begin
                        k_next = k_reg - K_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = smpp_pkg::BACK_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= smpp_pkg::BACK_IDLE;
        else
            state_reg <= state_next;
    end

    // Window, counters and output valid; the window resets to zero padding.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < WIN; j++)
                win_reg[j] <= '0;
            count_reg     <= '0;
            k_reg         <= '0;
            flush_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            for (int j = 0; j < WIN; j++)
                win_reg[j] <= win_next[j];
            count_reg     <= count_next;
            k_reg         <= k_next;
            flush_reg     <= flush_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload.
    always_ff @(posedge clk)
    begin
        index_reg <= index_next;
        peak_reg  <= peak_next;
        last_reg  <= last_next;
    end

    assign out_valid    = out_valid_reg;
    assign column_index = index_reg;
    assign is_peak      = peak_reg;
    assign last         = last_reg;

endmodule

/* sv/score_margin_peak_picker.sv */
// Score margin peak picker: scores in, one peak decision per column out.
// Throughput: one score per cycle while the four-column queue has room; the back end takes no new
// column while it emits decisions, up to radius+1 decisions on a sequence end.
// Input stalls on a full queue, which closely spaced columns, flushes or held results can fill.
// Reset: rst_n is asynchronous; window, counters and queue clear, radius = 2, threshold = 0.
module score_margin_peak_picker #(
    parameter int MAX_RADIUS  = 15,
    parameter int MAX_COLUMNS = 1024,
    parameter int SCORE_BITS  = 16
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    // Request side: tdata = score; tlast = column_end; tuser = sequence_end.
    input  logic                                     s_tvalid,
    output logic                                     s_tready,
    input  logic [((SCORE_BITS+7)/8)*8-1:0]          s_tdata,
    input  logic                                     s_tlast,
    input  logic                                     s_tuser,
    // Result side: tdata = column_index, is_peak, zero fill; tlast = last.
    output logic                                     m_tvalid,
    input  logic                                     m_tready,
    output logic [(($clog2(MAX_COLUMNS)+1+7)/8)*8-1:0] m_tdata,
    output logic                                     m_tlast,
    // Configuration write port.
    input  logic                                     cfg_we,
    input  logic [smpp_pkg::CFG_IDX_W-1:0]           cfg_idx,
    input  logic [smpp_pkg::CFG_DATA_W-1:0]          cfg_data
);

    localparam int IDX_W       = $clog2(MAX_COLUMNS);
    localparam int OUT_TDATA_W = ((IDX_W + 1 + 7) / 8) * 8;

    logic [smpp_pkg::RADIUS_W-1:0] radius_reg;
    logic [smpp_pkg::THRESH_W-1:0] thresh_reg;
    logic                          fe_valid;
    logic                          fe_ready;
    smpp_pkg::col_event_t          fe_ev;
    logic                          be_valid;
    logic                          be_ready;
    smpp_pkg::col_event_t          be_ev;
    logic [IDX_W-1:0]              column_index;
    logic                          is_peak;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= smpp_pkg::RADIUS_RESET;
            thresh_reg <= smpp_pkg::THRESH_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                smpp_pkg::CFG_RADIUS:
                    radius_reg <= cfg_data[smpp_pkg::RADIUS_W-1:0];
                smpp_pkg::CFG_MARGIN_THRESHOLD:
                    thresh_reg <= cfg_data[smpp_pkg::THRESH_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Front end: column statistics and margins.
    smpp_front #(
        .SCORE_BITS (SCORE_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .score        (s_tdata[SCORE_BITS-1:0]),
        .column_end   (s_tlast),
        .sequence_end (s_tuser),
        .ev_valid     (fe_valid),
        .ev_ready     (fe_ready),
        .ev           (fe_ev)
    );

    // Column queue.
    smpp_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (fe_valid),
        .wr_ready (fe_ready),
        .wr_data  (fe_ev),
        .rd_valid (be_valid),
        .rd_ready (be_ready),
        .rd_data  (be_ev)
    );

    // Back end: window and decisions.
    smpp_back #(
        .MAX_RADIUS  (MAX_RADIUS),
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .radius           (radius_reg),
        .margin_threshold (thresh_reg),
        .ev_valid         (be_valid),
        .ev_ready         (be_ready),
        .ev               (be_ev),
        .out_valid        (m_tvalid),
        .out_ready        (m_tready),
        .column_index     (column_index),
        .is_peak          (is_peak),
        .last             (m_tlast)
    );

    assign m_tdata = OUT_TDATA_W'({is_peak, column_index});

endmodule
